### sv/slf_pkg.sv
package slf_pkg;

    localparam int VALUE_BITS = 32;
    localparam int FACTOR_FRAC_BITS = 15;
    localparam int NUM_FIELDS = 5;
    localparam int IN_BITS = 32;
    localparam int OUT_BITS = 32;
    localparam int FACTOR_OUT_BITS = 16;
    localparam int FACTOR_BITS = FACTOR_FRAC_BITS + 1;
    localparam int MAG_BITS = VALUE_BITS + 1;
    localparam int DIFF_BITS = VALUE_BITS + 1;
    localparam int REM_BITS = MAG_BITS + 1;
    localparam int PROD_BITS = MAG_BITS + FACTOR_BITS;
    localparam int CNT_BITS = $clog2(FACTOR_FRAC_BITS + 1);
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE = FACTOR_BITS'(1) << FACTOR_FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_CENTRE    = 2'd0,
        MODE_NEIGHBOUR = 2'd1,
        MODE_NODE      = 2'd2,
        MODE_COEF      = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic signed [31:0]   density;
        logic signed [31:0]   momentum_x;
        logic signed [31:0]   momentum_y;
        logic signed [31:0]   momentum_z;
        logic signed [31:0]   energy;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]   scaled_density;
        logic signed [31:0]   scaled_momentum_x;
        logic signed [31:0]   scaled_momentum_y;
        logic signed [31:0]   scaled_momentum_z;
        logic signed [31:0]   scaled_energy;
        logic [15:0]          factor_density;
        logic [15:0]          factor_momentum_x;
        logic [15:0]          factor_momentum_y;
        logic [15:0]          factor_momentum_z;
        logic [15:0]          factor_energy;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic step;
        logic [1:0] mode;
    } lane_ctrl_t;

    function automatic logic signed [VALUE_BITS-1:0] load_value(logic [IN_BITS-1:0] raw);
        logic signed [63:0] ext;
        ext = 64'(signed'(raw));
        return ext[VALUE_BITS-1:0];
    endfunction

endpackage

### sv/slope_limiter_five_field_core.sv
// Barth-Jespersen slope limiter for five conserved fields.
// Input channel in_valid/in_ready carries one in_item_t request: a mode and
// five Q16.16 values. Centre requests open a cell, neighbour requests widen
// the bounds, node requests lower the five Q1.15 limiter factors and
// coefficient requests produce one result on out_valid/out_ready.
// Five lanes work side by side, one per field, each with its own radix-2
// divider; the lane outputs are merged into one out_item_t.
// Centre and neighbour requests update the lanes when taken. A node request
// loads the divider, lets it retire one quotient bit per step and then
// updates the factors; no request is taken meanwhile. A coefficient request
// shows its result in the cycle after acceptance and holds it until out_ready;
// no new request is taken while a result waits. After reset all bounds and
// centres are zero and every factor is one, so requests before the first
// centre act on an all-zero cell.
module slope_limiter_five_field_core
    import slf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    lane_ctrl_t ctrl;
    logic in_fire, out_fire;
    logic signed [VALUE_BITS-1:0] vals [NUM_FIELDS];
    logic signed [OUT_BITS-1:0] scaled [NUM_FIELDS];
    logic [FACTOR_BITS-1:0] factors [NUM_FIELDS];

    assign in_fire = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    assign vals[0] = load_value(in_data.density);
    assign vals[1] = load_value(in_data.momentum_x);
    assign vals[2] = load_value(in_data.momentum_y);
    assign vals[3] = load_value(in_data.momentum_z);
    assign vals[4] = load_value(in_data.energy);

    slf_core_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_mode(in_data.mode),
        .out_fire(out_fire), .in_ready(in_ready), .out_valid(out_valid), .ctrl(ctrl)
    );

    for (genvar g = 0; g < NUM_FIELDS; g++)
    begin : g_lane
        slf_lane u_lane (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .value(vals[g]),
            .scaled(scaled[g]), .factor(factors[g])
        );
    end

    always_comb
    begin
        out_data.scaled_density    = scaled[0];
        out_data.scaled_momentum_x = scaled[1];
        out_data.scaled_momentum_y = scaled[2];
        out_data.scaled_momentum_z = scaled[3];
        out_data.scaled_energy     = scaled[4];
        out_data.factor_density    = 16'(factors[0]);
        out_data.factor_momentum_x = 16'(factors[1]);
        out_data.factor_momentum_y = 16'(factors[2]);
        out_data.factor_momentum_z = 16'(factors[3]);
        out_data.factor_energy     = 16'(factors[4]);
    end

    a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input taken while result pending");
    a_fac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> factors[0] <= FACTOR_ONE)
        else $error("factor above one");

endmodule

### sv/slf_lane.sv
module slf_lane
    import slf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_ctrl_t                    ctrl,
    input  logic signed [VALUE_BITS-1:0]  value,
    output logic signed [OUT_BITS-1:0]    scaled,
    output logic [FACTOR_BITS-1:0]        factor
);

    logic signed [VALUE_BITS-1:0] centre_reg, lower_reg, upper_reg;
    logic [FACTOR_BITS-1:0]       lim_reg, lim_next;
    logic [REM_BITS-1:0]          rem_reg, rem_next;
    logic [MAG_BITS-1:0]          den_reg;
    logic [FACTOR_BITS-1:0]       quo_reg, quo_next;
    logic                         direct_reg;
    logic [FACTOR_BITS-1:0]       direct_val_reg;
    logic signed [OUT_BITS-1:0]   scaled_reg, scaled_next;

    logic signed [DIFF_BITS-1:0]  node_diff, bound_diff;
    logic [MAG_BITS-1:0]          num_mag, den_mag;
    logic [REM_BITS-1:0]          shifted;
    logic [MAG_BITS-1:0]          coef_mag;
    logic [PROD_BITS-1:0]         prod, prod_adj;
    logic [PROD_BITS-FACTOR_FRAC_BITS-1:0] prod_sh;
    logic [FACTOR_BITS-1:0]       cand;

    always_comb
    begin
        node_diff = DIFF_BITS'(value) - DIFF_BITS'(centre_reg);
        if (value > centre_reg)
            bound_diff = DIFF_BITS'(upper_reg) - DIFF_BITS'(centre_reg);
        else
            bound_diff = DIFF_BITS'(centre_reg) - DIFF_BITS'(lower_reg);
        num_mag = MAG_BITS'(bound_diff);
        den_mag = node_diff[DIFF_BITS-1] ? MAG_BITS'(-node_diff) : MAG_BITS'(node_diff);
        shifted = rem_reg << 1;
        if (shifted >= REM_BITS'(den_reg))
        begin
            rem_next = shifted - REM_BITS'(den_reg);
            quo_next = (quo_reg << 1) | FACTOR_BITS'(1);
        end
        else
        begin
            rem_next = shifted;
            quo_next = quo_reg << 1;
        end
        cand = direct_reg ? direct_val_reg : quo_reg;
        coef_mag = value[VALUE_BITS-1] ? MAG_BITS'(-DIFF_BITS'(value)) : MAG_BITS'(value);
        prod = PROD_BITS'(coef_mag) * PROD_BITS'(lim_reg);
        if (value[VALUE_BITS-1])
        begin
            prod_adj = prod + PROD_BITS'(FACTOR_ONE - FACTOR_BITS'(1));
            prod_sh = prod_adj[PROD_BITS-1:FACTOR_FRAC_BITS];
            scaled_next = OUT_BITS'(-prod_sh);
        end
        else
        begin
            prod_adj = prod;
            prod_sh = prod_adj[PROD_BITS-1:FACTOR_FRAC_BITS];
            scaled_next = OUT_BITS'(prod_sh);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            centre_reg <= '0;
            lower_reg  <= '0;
            upper_reg  <= '0;
        end
        else if (ctrl.start)
        begin
            case (ctrl.mode)
                MODE_CENTRE:
                begin
                    centre_reg <= value;
                    lower_reg  <= value;
                    upper_reg  <= value;
                end
                MODE_NEIGHBOUR:
                begin
                    if (value < lower_reg)
                        lower_reg <= value;
                    if (value > upper_reg)
                        upper_reg <= value;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Divider: loaded on every accepted request; a node request then steps it one quotient bit per step.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= REM_BITS'(num_mag);
            den_reg <= den_mag;
            quo_reg <= '0;
            direct_reg <= (node_diff == '0) || (num_mag >= den_mag);
            direct_val_reg <= FACTOR_ONE;
            scaled_reg <= scaled_next;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign lim_next = (ctrl.mode == MODE_NODE && !ctrl.start && !ctrl.step && cand < lim_reg)
                      ? cand : lim_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_reg <= FACTOR_ONE;
        else if (ctrl.start && ctrl.mode == MODE_CENTRE)
            lim_reg <= FACTOR_ONE;
        else
            lim_reg <= lim_next;
    end

    assign scaled = scaled_reg;
    assign factor = lim_reg;

endmodule

### sv/slf_core_ctrl.sv
module slf_core_ctrl
    import slf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [1:0] in_mode,
    input  logic       out_fire,
    output logic       in_ready,
    output logic       out_valid,
    output lane_ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0] mode_reg, mode_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        mode_next = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    mode_next = in_mode;
                    cnt_next = '0;
                    if (in_mode == MODE_NODE)
                        state_next = ST_DIV;
                    else if (in_mode == MODE_COEF)
                        state_next = ST_OUT;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == CNT_BITS'(FACTOR_FRAC_BITS))
                begin
                    state_next = ST_IDLE;
                    mode_next = MODE_CENTRE;
                end
                else
                    cnt_next = cnt_reg + CNT_BITS'(1);
            end
            ST_OUT:
            begin
                if (out_fire)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        ctrl.start = in_fire;
        ctrl.step = (state_reg == ST_DIV) && (cnt_reg != CNT_BITS'(FACTOR_FRAC_BITS));
        ctrl.mode = in_fire ? in_mode : mode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            mode_reg <= MODE_CENTRE;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            mode_reg <= mode_next;
        end
    end

endmodule

### test/slope_limiter_five_field_core_tb.sv
module slope_limiter_five_field_core_tb;
    import slf_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_RANDOM = 450;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    slope_limiter_five_field_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Cell state of the limiter as the predictor sees it.
    logic signed [VALUE_BITS-1:0] cell_centre [NUM_FIELDS];
    logic signed [VALUE_BITS-1:0] cell_low [NUM_FIELDS];
    logic signed [VALUE_BITS-1:0] cell_high [NUM_FIELDS];
    logic [FACTOR_BITS-1:0]       cell_factor [NUM_FIELDS];

    in_item_t  pending_requests [$];
    out_item_t expected_coefs [$];

    int  mismatches;
    int  requests_sent;
    int  results_seen;
    int  node_count;
    int  coef_count;
    int  idle_cycles;
    int  in_gap;
    int  out_gap;
    bit  in_accepted;
    bit  out_taken;
    bit  hold_sender;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [FACTOR_BITS-1:0] limit_ratio(logic [MAG_BITS-1:0] num,
                                                          logic [MAG_BITS-1:0] den);
        logic [REM_BITS-1:0]    rem;
        logic [FACTOR_BITS-1:0] q;
        q = '0;
        if (num >= den)
            return FACTOR_ONE;
        rem = REM_BITS'(num);
        for (int i = 0; i < FACTOR_FRAC_BITS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= REM_BITS'(den)) begin
                rem = rem - REM_BITS'(den);
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [31:0] scale_coef(logic signed [VALUE_BITS-1:0] coef,
                                               logic [FACTOR_BITS-1:0] factor);
        logic [63:0] mag;
        logic [63:0] prod;
        logic [63:0] res;
        mag = coef < 0 ? 64'(-65'(coef)) : 64'(coef);
        prod = mag * 64'(factor);
        if (coef < 0)
            res = -((prod + 64'(FACTOR_ONE) - 64'd1) >> FACTOR_FRAC_BITS);
        else
            res = prod >> FACTOR_FRAC_BITS;
        return res[31:0];
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] field_value(in_item_t req, int f);
        logic [31:0] raw;
        case (f)
            0: raw = req.density;
            1: raw = req.momentum_x;
            2: raw = req.momentum_y;
            3: raw = req.momentum_z;
            default: raw = req.energy;
        endcase
        return VALUE_BITS'(signed'(raw));
    endfunction

    task automatic predict_limiter(input in_item_t req);
        logic signed [VALUE_BITS-1:0] v;
        logic signed [DIFF_BITS-1:0]  c;
        logic signed [DIFF_BITS-1:0]  n;
        logic [FACTOR_BITS-1:0]       k;
        logic [31:0]                  sc [NUM_FIELDS];
        logic [15:0]                  fo [NUM_FIELDS];
        out_item_t                    exp_item;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            v = field_value(req, f);
            case (mode_t'(req.mode))
                MODE_CENTRE: begin
                    cell_centre[f] = v;
                    cell_low[f] = v;
                    cell_high[f] = v;
                    cell_factor[f] = FACTOR_ONE;
                end
                MODE_NEIGHBOUR: begin
                    if (v < cell_low[f])
                        cell_low[f] = v;
                    if (v > cell_high[f])
                        cell_high[f] = v;
                end
                MODE_NODE: begin
                    c = DIFF_BITS'(cell_centre[f]);
                    n = DIFF_BITS'(v);
                    if (n == c)
                        k = FACTOR_ONE;
                    else if (n > c)
                        k = limit_ratio(MAG_BITS'(DIFF_BITS'(cell_high[f]) - c),
                                        MAG_BITS'(n - c));
                    else
                        k = limit_ratio(MAG_BITS'(c - DIFF_BITS'(cell_low[f])),
                                        MAG_BITS'(c - n));
                    if (k < cell_factor[f])
                        cell_factor[f] = k;
                end
                default: begin
                    sc[f] = scale_coef(v, cell_factor[f]);
                    fo[f] = 16'(cell_factor[f]);
                end
            endcase
        end
        if (mode_t'(req.mode) == MODE_COEF) begin
            exp_item = '{sc[0], sc[1], sc[2], sc[3], sc[4], fo[0], fo[1], fo[2], fo[3], fo[4]};
            expected_coefs.push_back(exp_item);
        end
    endtask

    function automatic logic [31:0] rand_value(int style);
        case (style)
            0: return $urandom();
            1: return 32'(signed'($urandom_range(0, 8191)) - 4096);
            2: return 32'h7FFF_FFFF;
            default: return 32'h8000_0000;
        endcase
    endfunction

    function automatic in_item_t make_request(mode_t m, int style);
        in_item_t r;
        r.mode = m;
        r.density = rand_value(style);
        r.momentum_x = rand_value(style);
        r.momentum_y = rand_value(style);
        r.momentum_z = rand_value(style);
        r.energy = rand_value(style);
        return r;
    endfunction

    function automatic in_item_t fill_request(mode_t m, logic [31:0] val);
        in_item_t r;
        r.mode = m;
        r.density = val;
        r.momentum_x = val;
        r.momentum_y = val;
        r.momentum_z = val;
        r.energy = val;
        return r;
    endfunction

    function automatic int pick_style();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 1;
        if (r < 17)
            return 0;
        return r < 18 ? 2 : 3;
    endfunction

    // Driver: requests change on the falling edge, gaps drawn per request.
    always @(negedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data <= '0;
            in_gap <= 0;
        end else if (in_valid && !in_accepted) begin
        end else if (in_gap > 0) begin
            in_valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (pending_requests.size() != 0 && !(hold_sender && expected_coefs.size() != 0))
        begin
            predict_limiter(pending_requests[0]);
            in_data <= pending_requests.pop_front();
            in_valid <= 1'b1;
            in_gap <= $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
            requests_sent <= requests_sent + 1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    always @(posedge clk) begin
        in_accepted <= in_valid && in_ready;
    end

    // Ready side: a gap is drawn after every accepted result.
    always @(negedge clk or negedge rst_n) begin
        int gap;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap <= 0;
        end else if (out_taken) begin
            gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 9);
            out_ready <= (gap == 0);
            out_gap <= (gap == 0) ? 0 : gap - 1;
        end else if (out_gap > 0) begin
            out_ready <= 1'b0;
            out_gap <= out_gap - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: results checked at the rising edge against the oldest expectation.
    always @(posedge clk) begin
        out_item_t exp_item;
        out_taken <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready) begin
            results_seen <= results_seen + 1;
            if (expected_coefs.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected result %h", out_data);
            end else begin
                exp_item = expected_coefs.pop_front();
                if (out_data !== exp_item) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("result mismatch: expected %h actual %h", exp_item, out_data);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("slope_limiter_five_field_core_tb: done, errors");
            $finish;
        end
    end

    initial begin
        mode_t m;
        int    r;
        for (int f = 0; f < NUM_FIELDS; f++) begin
            cell_centre[f] = '0;
            cell_low[f] = '0;
            cell_high[f] = '0;
            cell_factor[f] = FACTOR_ONE;
        end
        node_count = 0;
        coef_count = 0;
        hold_sender = 1'b0;
        rst_n = 1'b0;

        // Requests before any centre act on the all-zero cell.
        pending_requests.push_back(fill_request(MODE_NODE, 32'h0001_0000));
        pending_requests.push_back(fill_request(MODE_COEF, 32'h7FFF_FFFF));
        pending_requests.push_back(fill_request(MODE_NEIGHBOUR, 32'h8000_0000));
        pending_requests.push_back(fill_request(MODE_NODE, 32'hFFFF_0000));
        pending_requests.push_back(fill_request(MODE_COEF, 32'h8000_0000));
        // Extreme bounds, nodes on them, and a node far outside the bounds.
        pending_requests.push_back(fill_request(MODE_CENTRE, 32'h0000_0000));
        pending_requests.push_back(fill_request(MODE_NEIGHBOUR, 32'h7FFF_FFFF));
        pending_requests.push_back(fill_request(MODE_NEIGHBOUR, 32'h8000_0000));
        pending_requests.push_back(fill_request(MODE_NODE, 32'h7FFF_FFFF));
        pending_requests.push_back(fill_request(MODE_NODE, 32'h8000_0000));
        pending_requests.push_back(fill_request(MODE_COEF, 32'hFFFF_FFFF));
        pending_requests.push_back(fill_request(MODE_CENTRE, 32'h8000_0000));
        pending_requests.push_back(fill_request(MODE_NODE, 32'h7FFF_FFFF));
        pending_requests.push_back(fill_request(MODE_COEF, 32'h0001_0000));
        // Node equal to centre, and a node below with a bound equal to the centre.
        pending_requests.push_back(fill_request(MODE_CENTRE, 32'h0003_0000));
        pending_requests.push_back(fill_request(MODE_NEIGHBOUR, 32'h0005_0000));
        pending_requests.push_back(fill_request(MODE_NODE, 32'h0003_0000));
        pending_requests.push_back(fill_request(MODE_COEF, 32'h0002_0000));
        pending_requests.push_back(fill_request(MODE_NODE, 32'h0009_0000));
        pending_requests.push_back(fill_request(MODE_NODE, 32'h0001_0000));
        pending_requests.push_back(fill_request(MODE_COEF, 32'hFFFE_8001));

        // Random cells: a centre, neighbours, nodes and coefficients.
        while (pending_requests.size() < NUM_RANDOM + 21) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                m = mode_t'($urandom_range(0, 3));
                pending_requests.push_back(make_request(m, pick_style()));
            end else begin
                pending_requests.push_back(make_request(MODE_CENTRE, pick_style()));
                repeat ($urandom_range(0, 4))
                    pending_requests.push_back(make_request(MODE_NEIGHBOUR, pick_style()));
                repeat ($urandom_range(0, 3)) begin
                    pending_requests.push_back(make_request(MODE_NODE, pick_style()));
                    if ($urandom_range(0, 1))
                        pending_requests.push_back(make_request(MODE_COEF, pick_style()));
                end
                pending_requests.push_back(make_request(MODE_COEF, pick_style()));
            end
        end
        foreach (pending_requests[i]) begin
            if (mode_t'(pending_requests[i].mode) == MODE_NODE)
                node_count++;
            if (mode_t'(pending_requests[i].mode) == MODE_COEF)
                coef_count++;
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // The sender pauses once until every result has drained.
        wait (requests_sent >= 200);
        hold_sender = 1'b1;
        while (expected_coefs.size() != 0)
            @(posedge clk);
        @(posedge clk);
        hold_sender = 1'b0;

        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_coefs.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d requests (%0d node, %0d coefficient) over random cells,",
                 requests_sent, node_count, coef_count);
        $display("checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && expected_coefs.size() == 0)
            $display("slope_limiter_five_field_core_tb: done, clean");
        else
            $display("slope_limiter_five_field_core_tb: done, errors");
        $finish;
    end

endmodule
